/* sv/lzw_encoder_assert.svh */
// Assertion helpers for the encoder
`ifndef LZW_ENCODER_ASSERT_SVH
`define LZW_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define LZWE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lzw_encoder check failed");

// Next-cycle implication, disabled during reset
`define LZWE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lzw_encoder check failed");

`endif

/* sv/lzwe_pkg.sv */
package lzwe_pkg;

   // request: one raw byte of the chunk
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // result: one emitted code or the chunk terminator
   typedef struct packed {
      logic [11:0] code;
      logic        end_marker;
      logic        last;
   } rsp_type;

   localparam int unsigned FIRST_FREE_CODE = 256;
   localparam logic [7:0]  DEFAULT_MAX_LEN = 8'd50;
   localparam logic [31:0] HASH_MULT       = 32'h9E37_79B1;
   localparam int unsigned HASH_SHIFT      = 7;

   // register byte addresses
   localparam logic [1:0]  REG_MAX_STRING_LENGTH = 2'd0;

endpackage

/* sv/lzwe_dict.sv */
module lzwe_dict #(
   parameter int unsigned ADDR_W = 13,
   parameter int unsigned DATA_W = 33
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/lzw_encoder.sv */
// LZW encoder: one byte per request, up to three result codes per request.
// A byte that starts a prefix needs no lookup; any other byte is hashed and then
// probed with one dictionary read per hash probe, and each emitted code may wait
// on rsp_stall. req_stall holds off the next byte until this one is done.
// After the last byte of a chunk, and after reset, a clearing pass writes
// every one of the HASH_SLOTS dictionary entries, one per cycle.
// Reset is synchronous, active high; max_string_length returns to 50.
module lzw_encoder
   import lzwe_pkg::*;
#(
   parameter int unsigned CODE_BITS  = 12,
   parameter int unsigned HASH_SLOTS = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

`include "lzw_encoder_assert.svh"

   localparam int unsigned SLOT_W  = $clog2(HASH_SLOTS);
   localparam int unsigned KEY_W   = CODE_BITS + 8;
   localparam int unsigned ENTRY_W = 1 + KEY_W + CODE_BITS;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_HASH, S_READ, S_CMP,
      S_EMIT_PREFIX, S_EMIT_FINAL, S_EMIT_END
   } state_type;

   state_type            state_ff;
   logic [SLOT_W-1:0]    clr_cnt_ff;
   logic [CODE_BITS-1:0] prefix_code_ff;
   logic                 prefix_valid_ff;
   logic [7:0]           prefix_len_ff;
   logic [CODE_BITS:0]   next_code_ff;
   logic [7:0]           max_len_ff;
   logic [7:0]           byte_ff;
   logic                 lastb_ff;
   logic                 fits_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [31:0]          prod_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [SLOT_W-1:0]    probe_cnt_ff;
   logic [CODE_BITS-1:0] emit_code_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   logic                 rd_en;
   logic [ENTRY_W-1:0]   rd_entry;
   logic                 wr_en;
   logic [SLOT_W-1:0]    wr_addr;
   logic [ENTRY_W-1:0]   wr_entry;

   logic                 ent_valid;
   logic [KEY_W-1:0]     ent_key;
   logic [CODE_BITS-1:0] ent_code;
   logic                 ent_match;
   logic                 probe_done;
   logic                 code_free;
   logic [7:0]           max_eff;
   logic [8:0]           len_plus;
   logic                 req_take;
   logic                 out_free;
   logic                 emit_now;
   logic [KEY_W-1:0]     key_in;
   logic [CODE_BITS+11:0] emit_ext;
   logic [CODE_BITS+11:0] prefix_ext;

   // dictionary memory: {valid, key, code}
   lzwe_dict #(
      .ADDR_W (SLOT_W),
      .DATA_W (ENTRY_W)
   ) u_dict (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (slot_ff),
      .rd_data (rd_entry),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry)
   );

   // probe decode
   assign ent_valid  = rd_entry[ENTRY_W-1];
   assign ent_key    = rd_entry[ENTRY_W-2 -: KEY_W];
   assign ent_code   = rd_entry[CODE_BITS-1:0];
   assign ent_match  = ent_valid && (ent_key == key_ff);
   assign probe_done = !ent_valid || ent_match || (probe_cnt_ff == SLOT_W'(HASH_SLOTS - 1));
   assign code_free  = !next_code_ff[CODE_BITS];

   // handshake and misc
   assign req_take   = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit_now   = out_free && (state_ff inside {S_EMIT_PREFIX, S_EMIT_FINAL, S_EMIT_END});
   assign max_eff    = (max_len_ff == 8'd0) ? 8'd1 : max_len_ff;
   assign len_plus   = {1'b0, prefix_len_ff} + 9'd1;
   assign key_in     = {prefix_code_ff, req_data.data_byte};
   assign emit_ext   = {12'd0, emit_code_ff};
   assign prefix_ext = {12'd0, prefix_code_ff};

   // memory access control
   assign rd_en = (state_ff == S_READ);
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = slot_ff;
      wr_entry = {1'b1, key_ff, next_code_ff[CODE_BITS-1:0]};
      if (state_ff == S_CLEAR) begin
         wr_en    = 1'b1;
         wr_addr  = clr_cnt_ff;
         wr_entry = '0;
      end else if (state_ff == S_CMP && probe_done && !(fits_ff && ent_match)
                   && code_free && (ent_match || !ent_valid)) begin
         wr_en = 1'b1;
      end
   end

   // configuration port
   assign pready = 1'b1;
   assign prdata = {24'd0, max_len_ff};

   // main sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         clr_cnt_ff      <= '0;
         prefix_code_ff  <= '0;
         prefix_valid_ff <= 1'b0;
         prefix_len_ff   <= '0;
         next_code_ff    <= (CODE_BITS+1)'(FIRST_FREE_CODE);
         max_len_ff      <= DEFAULT_MAX_LEN;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (psel && penable && pwrite && paddr == REG_MAX_STRING_LENGTH) begin
            max_len_ff <= pwdata[7:0];
         end
         // result register: load on emit, drop once taken
         if (emit_now) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + SLOT_W'(1);
               if (clr_cnt_ff == SLOT_W'(HASH_SLOTS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_take) begin
                  byte_ff  <= req_data.data_byte;
                  lastb_ff <= req_data.last_byte;
                  if (!prefix_valid_ff) begin
                     prefix_code_ff  <= CODE_BITS'(req_data.data_byte);
                     prefix_valid_ff <= 1'b1;
                     prefix_len_ff   <= 8'd1;
                     if (req_data.last_byte) begin
                        state_ff <= S_EMIT_FINAL;
                     end
                  end else begin
                     key_ff   <= key_in;
                     fits_ff  <= (len_plus <= {1'b0, max_eff});
                     prod_ff  <= 32'(key_in) * HASH_MULT;
                     state_ff <= S_HASH;
                  end
               end
            end
            S_HASH: begin
               slot_ff      <= prod_ff[HASH_SHIFT +: SLOT_W];
               probe_cnt_ff <= '0;
               state_ff     <= S_READ;
            end
            S_READ: begin
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (!probe_done) begin
                  slot_ff      <= slot_ff + SLOT_W'(1);
                  probe_cnt_ff <= probe_cnt_ff + SLOT_W'(1);
                  state_ff     <= S_READ;
               end else if (fits_ff && ent_match) begin
                  // extend the prefix
                  prefix_code_ff <= ent_code;
                  prefix_len_ff  <= prefix_len_ff + 8'd1;
                  state_ff       <= lastb_ff ? S_EMIT_FINAL : S_IDLE;
               end else begin
                  // emit the prefix, allocate a code if one is free, restart at the byte
                  emit_code_ff   <= prefix_code_ff;
                  if (code_free) begin
                     next_code_ff <= next_code_ff + (CODE_BITS+1)'(1);
                  end
                  prefix_code_ff <= CODE_BITS'(byte_ff);
                  prefix_len_ff  <= 8'd1;
                  state_ff       <= S_EMIT_PREFIX;
               end
            end
            S_EMIT_PREFIX: begin
               if (out_free) begin
                  rsp_data_ff.code       <= emit_ext[11:0];
                  rsp_data_ff.end_marker <= 1'b0;
                  rsp_data_ff.last       <= !lastb_ff;
                  state_ff               <= lastb_ff ? S_EMIT_FINAL : S_IDLE;
               end
            end
            S_EMIT_FINAL: begin
               if (out_free) begin
                  rsp_data_ff.code       <= prefix_ext[11:0];
                  rsp_data_ff.end_marker <= 1'b0;
                  rsp_data_ff.last       <= 1'b0;
                  state_ff               <= S_EMIT_END;
               end
            end
            S_EMIT_END: begin
               if (out_free) begin
                  rsp_data_ff.code       <= 12'd0;
                  rsp_data_ff.end_marker <= 1'b1;
                  rsp_data_ff.last       <= 1'b1;
                  prefix_code_ff         <= '0;
                  prefix_valid_ff        <= 1'b0;
                  prefix_len_ff          <= '0;
                  next_code_ff           <= (CODE_BITS+1)'(FIRST_FREE_CODE);
                  clr_cnt_ff             <= '0;
                  state_ff               <= S_CLEAR;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `LZWE_ASSERT_NOW(a_code_bound, clock, reset, 1'b1,
      next_code_ff <= (CODE_BITS+1)'(2**CODE_BITS))
   `LZWE_ASSERT_NOW(a_prefix_len, clock, reset, prefix_valid_ff, prefix_len_ff != 8'd0)
   `LZWE_ASSERT_NOW(a_write_src, clock, reset, wr_en,
      state_ff == S_CLEAR || state_ff == S_CMP)
   `LZWE_ASSERT_NEXT(a_clear_end, clock, reset,
      state_ff == S_CLEAR && clr_cnt_ff == SLOT_W'(HASH_SLOTS - 1), state_ff == S_IDLE)

endmodule

/* tb/tb_lzw_encoder.sv */
`timescale 1ns / 100ps

module tb_lzw_encoder
   import lzwe_pkg::*;
();

   localparam int DICT_SLOTS  = 8192;
   localparam int CODE_SPACE  = 4096;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE      = 64;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [1:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   lzw_encoder uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // shadow encoder state
   bit          dict_used [DICT_SLOTS];
   logic [19:0] dict_key  [DICT_SLOTS];
   logic [11:0] dict_code [DICT_SLOTS];
   logic [11:0] cur_code;
   bit          cur_valid;
   int          cur_len;
   int          next_free;
   logic [7:0]  max_len;

   rsp_type     code_queue[$];
   int          errors;
   int          cycles;
   int          sent_bytes;
   int          checked_codes;
   int          hold_cycles;
   bit          quiet;

   // clock and run limit
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("lzw_encoder: mismatch");
         $finish;
      end
   end

   // result stall: long hold when requested, none when quiet, otherwise random
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall = 1'b1;
         hold_cycles = hold_cycles - 1;
      end else if (quiet) begin
         rsp_stall = 1'b0;
      end else begin
         rsp_stall = ($urandom_range(0, 99) < 25);
         if ($urandom_range(0, 199) == 0) hold_cycles = $urandom_range(10, 40);
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (code_queue.size() == 0) begin
            errors = errors + 1;
            $display("%0t: unexpected result %h", $realtime, rsp_data);
         end else begin
            want = code_queue.pop_front();
            checked_codes = checked_codes + 1;
            if (rsp_data.code !== want.code) begin
               errors = errors + 1;
               $display("%0t: code expected %0d actual %0d", $realtime, want.code,
                        rsp_data.code);
            end
            if (rsp_data.end_marker !== want.end_marker) begin
               errors = errors + 1;
               $display("%0t: end_marker expected %0d actual %0d", $realtime,
                        want.end_marker, rsp_data.end_marker);
            end
            if (rsp_data.last !== want.last) begin
               errors = errors + 1;
               $display("%0t: last expected %0d actual %0d", $realtime, want.last,
                        rsp_data.last);
            end
         end
      end
   end

   function automatic void clear_dictionary();
      for (int i = 0; i < DICT_SLOTS; i++) begin
         dict_used[i] = 0;
         dict_key[i] = '0;
         dict_code[i] = '0;
      end
      cur_code = '0;
      cur_valid = 0;
      cur_len = 0;
      next_free = FIRST_FREE_CODE;
   endfunction

   // linear probe: 1 found, 0 free slot, -1 table full
   function automatic int lookup_slot(input logic [19:0] key, output int slot);
      logic [31:0] h;
      int          s;
      h = {12'd0, key} * HASH_MULT;
      slot = 0;
      for (int i = 0; i < DICT_SLOTS; i++) begin
         s = (int'(h >> HASH_SHIFT) + i) % DICT_SLOTS;
         if (!dict_used[s]) begin
            slot = s;
            return 0;
         end
         if (dict_key[s] == key) begin
            slot = s;
            return 1;
         end
      end
      return -1;
   endfunction

   function automatic void push_code(input logic [11:0] c, input bit term, input bit fin);
      rsp_type r;
      r.code = term ? 12'd0 : c;
      r.end_marker = term;
      r.last = fin;
      code_queue = {code_queue, r};
   endfunction

   // expected codes for one accepted byte
   function automatic void encode_byte(input logic [7:0] b, input bit fin);
      logic [19:0] key;
      int          slot;
      int          hit;
      int          limit;
      int          emitted;
      bit          fits;
      limit = (max_len == 0) ? 1 : int'(max_len);
      emitted = 0;
      if (!cur_valid) begin
         cur_code = {4'd0, b};
         cur_valid = 1;
         cur_len = 1;
      end else begin
         key = {cur_code, b};
         fits = (cur_len + 1 <= limit);
         hit = 0;
         if (fits) hit = lookup_slot(key, slot);
         if (fits && hit == 1) begin
            cur_code = dict_code[slot];
            cur_len = cur_len + 1;
         end else begin
            push_code(cur_code, 0, 0);
            emitted = 1;
            if (next_free < CODE_SPACE) begin
               hit = lookup_slot(key, slot);
               if (hit >= 0) begin
                  dict_used[slot] = 1;
                  dict_key[slot] = key;
                  dict_code[slot] = next_free[11:0];
               end
               next_free = next_free + 1;
            end
            cur_code = {4'd0, b};
            cur_len = 1;
         end
      end
      if (fin) begin
         push_code(cur_code, 0, 0);
         push_code('0, 1, 1);
         clear_dictionary();
      end else if (emitted > 0) begin
         code_queue[code_queue.size() - 1].last = 1;
      end
   endfunction

   // send one byte; called and returns at a falling edge
   task automatic send_byte(input logic [7:0] b, input bit fin);
      int gap;
      int r;
      req_valid = 1'b1;
      req_data.data_byte = b;
      req_data.last_byte = fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      encode_byte(b, fin);
      sent_bytes = sent_bytes + 1;
      @(negedge clock);
      r = $urandom_range(0, 99);
      gap = 0;
      if (!quiet) begin
         if (r >= 90) gap = $urandom_range(10, 40);
         else if (r >= 60) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (code_queue.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_max_len(input logic [7:0] v);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = REG_MAX_STRING_LENGTH;
      pwdata = {24'd0, v};
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      max_len = v;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic read_max_len();
      psel = 1'b1;
      pwrite = 1'b0;
      penable = 1'b0;
      paddr = REG_MAX_STRING_LENGTH;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[7:0] !== max_len) begin
         errors = errors + 1;
         $display("%0t: max_string_length expected %0d actual %0d", $realtime, max_len,
                  prdata[7:0]);
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   // random chunk; small alphabets make long dictionary strings
   task automatic send_chunk(input int len, input int alphabet);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         b = (alphabet >= 256) ? 8'($urandom_range(0, 255))
                               : 8'($urandom_range(0, alphabet - 1) * 37 + 200);
         send_byte(b, i == len - 1);
      end
   endtask

   // extremes, repeats, single-byte chunk, register change mid-chunk
   task automatic test_directed();
      read_max_len();
      send_byte(8'h00, 0);
      send_byte(8'hFF, 0);
      send_byte(8'h00, 0);
      send_byte(8'hFF, 0);
      for (int i = 0; i < 8; i++) send_byte(8'h61, i == 7);
      send_byte(8'hAA, 1);
      for (int i = 0; i < 5; i++) send_byte(8'h55, 0);
      drain();
      write_max_len(8'd2);
      read_max_len();
      for (int i = 0; i < 5; i++) send_byte(8'h55, i == 4);
      drain();
   endtask

   // zero maximum behaves as one
   task automatic test_zero_max();
      write_max_len(8'd0);
      read_max_len();
      for (int i = 0; i < 8; i++) send_byte(i[0] ? 8'h62 : 8'h61, i == 7);
      drain();
   endtask

   // random chunks under several maxima
   task automatic test_random_chunks();
      logic [7:0] settings [5];
      settings = '{8'd1, 8'd2, 8'd3, 8'd255, 8'd7};
      for (int p = 0; p < 5; p++) begin
         write_max_len(settings[p]);
         quiet = (p == 2);
         for (int c = 0; c < 4; c++)
            send_chunk($urandom_range(1, 10), (c == 3) ? 256 : $urandom_range(2, 4));
         drain();
      end
      quiet = 0;
      write_max_len(8'd50);
      send_chunk(30, 3);
      drain();
   endtask

   // receiver holds off while bytes keep coming
   task automatic test_backpressure();
      hold_cycles = 400;
      send_chunk(40, 256);
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      errors = 0;
      cycles = 0;
      sent_bytes = 0;
      checked_codes = 0;
      hold_cycles = 0;
      quiet = 0;
      max_len = DEFAULT_MAX_LEN;
      clear_dictionary();
      repeat (3) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_zero_max();
      test_random_chunks();
      test_backpressure();
      drain();
      $display("covered %0d bytes and %0d codes: extremes, maxima 0..255,", sent_bytes,
               checked_codes);
      $display("random gaps and stalls, and a long result stall with a full pipeline");
      if (errors == 0)
         $display("lzw_encoder: match");
      else
         $display("lzw_encoder: mismatch");
      $finish;
   end

endmodule
